### src/rmp_pkg.sv
// ----------------------------------------------------------------------------
// RTTTL melody parser package
// Shared types, constants and the note letter lookup for the parser.
// ----------------------------------------------------------------------------
package rmp_pkg;

  // Parser phase within the ringtone string.
  typedef enum logic [4:0] {
    PH_NAME, PH_HD, PH_DEQ, PH_DNUM, PH_HO, PH_OEQ, PH_ODIG, PH_OCOMMA,
    PH_HB, PH_BEQ, PH_BNUM, PH_NSTART, PH_NSHARP, PH_NDOT, PH_NOCT,
    PH_NCOMMA, PH_DONE
  } phase_t;

  // Sequencer state around one character.
  typedef enum logic [2:0] {
    C_IDLE, C_STEP, C_HDR_DIV, C_NOTE_DIV
  } ctl_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_DUR   = 2'd0;
  localparam logic [1:0] REG_OCT   = 2'd1;
  localparam logic [1:0] REG_TEMPO = 2'd2;

  localparam logic [7:0]  RST_DUR   = 8'd4;
  localparam logic [2:0]  RST_OCT   = 3'd6;
  localparam logic [15:0] RST_TEMPO = 16'd63;

  localparam int DIV_N = 18;
  localparam int DIV_D = 16;
  localparam logic [DIV_N-1:0] MS_PER_MIN = 18'd60000;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_B     = 8'h62;

  // Semitone of a note letter; anything else is a rest.
  function automatic logic [3:0] letter_semitone(input logic [7:0] c);
    case (c)
      8'h63:   return 4'd1;
      8'h64:   return 4'd3;
      8'h65:   return 4'd5;
      8'h66:   return 4'd6;
      8'h67:   return 4'd8;
      8'h61:   return 4'd10;
      8'h62:   return 4'd12;
      default: return 4'd0;
    endcase
  endfunction

endpackage

### src/rmp_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rmp_pkg::DIV_N-1:0]  dividend,
  input  logic [rmp_pkg::DIV_D-1:0]  divisor,
  output logic                       done,
  output logic [rmp_pkg::DIV_N-1:0]  quotient
);
  import rmp_pkg::*;

  logic                busy;
  logic [4:0]          cnt;
  logic [DIV_D:0]      rem;
  logic [DIV_D-1:0]    dvs;
  logic [DIV_D:0]      rem_sh;
  logic                fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign rem_sh = {rem[DIV_D-1:0], quotient[DIV_N-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= 5'(DIV_N);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
        quotient <= {quotient[DIV_N-2:0], fits};
        cnt      <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The divider only finishes a division it has started.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without work");
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy && !start |-> cnt != 5'd0) else $error("divider count ran out");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done held");

endmodule

### src/rmp_apb.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style access to the fallback duration, octave and tempo registers.
// ----------------------------------------------------------------------------
module rmp_apb (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  fb_dur,
  output logic [2:0]  fb_oct,
  output logic [15:0] fb_tempo
);
  import rmp_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register writes at the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_dur   <= RST_DUR;
      fb_oct   <= RST_OCT;
      fb_tempo <= RST_TEMPO;
    end else if (wr) begin
      case (paddr[3:2])
        REG_DUR:   fb_dur   <= pwdata[7:0];
        REG_OCT:   fb_oct   <= pwdata[2:0];
        REG_TEMPO: fb_tempo <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (paddr[3:2])
      REG_DUR:   prdata = {24'd0, fb_dur};
      REG_OCT:   prdata = {29'd0, fb_oct};
      REG_TEMPO: prdata = {16'd0, fb_tempo};
      default:   prdata = '0;
    endcase
  end

endmodule

### src/rtttl_melody_parser_unit.sv
// ----------------------------------------------------------------------------
// RTTTL melody parser
// Parses an RTTTL ringtone one character per transfer into note events.
// ----------------------------------------------------------------------------
// Each character transfer is taken and then passes through one or more parser
// phases in turn. A character that ends the header or starts a note also runs
// the shared serial divider (60000/bpm or whole-note time / divisor). A
// character that ends a header without b= and also starts a note runs both
// divisions. The block takes no new character while it works on one. It also
// waits while a finished note cannot be written because the previous event has
// not been taken. A note event leaves on the character after the note, or on
// NUL with song_end. Fallback registers take effect at the next song_start.
module rtttl_melody_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        song_start,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_rest,
  output logic signed [7:0] note_index,
  output logic [18:0] duration_ms,
  output logic        song_end
);
  import rmp_pkg::*;

  logic [7:0]  fb_dur;
  logic [2:0]  fb_oct;
  logic [15:0] fb_tempo;

  ctl_t   ctl, ctl_next;
  phase_t phase, phase_next;
  logic [7:0]  chr, chr_next;
  logic [15:0] accum, accum_next;
  logic [7:0]  dflt_dur, dflt_dur_next;
  logic [3:0]  dflt_oct, dflt_oct_next;
  logic [15:0] tempo, tempo_next;
  logic [17:0] whole_ms, whole_ms_next;
  logic [3:0]  p_semi, p_semi_next;
  logic [3:0]  p_oct, p_oct_next;
  logic [18:0] p_dur, p_dur_next;
  logic        p_valid, p_valid_next;
  logic        hdr_redo, hdr_redo_next;

  logic        div_start, div_done;
  logic [DIV_N-1:0] div_dividend, div_q;
  logic [DIV_D-1:0] div_divisor;

  logic        emit, em_rest, em_end;
  logic [7:0]  em_idx;
  logic [18:0] em_dur;
  logic        out_free, is_dig;
  logic [3:0]  dig;
  logic [19:0] acc_mul;
  logic [7:0]  idx_raw;

  rmp_apb u_apb (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fb_dur, .fb_oct, .fb_tempo
  );

  rmp_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q)
  );

  assign in_ready = (ctl == C_IDLE);
  assign out_free = !out_valid || out_ready;
  assign is_dig   = (chr >= CH_ZERO) && (chr <= 8'h39);
  assign dig      = 4'(chr - CH_ZERO);

  // Decimal accumulate with saturation at the 16-bit limit.
  assign acc_mul = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {16'd0, dig};

  // Pitch index of the pending note.
  assign idx_raw = {1'b0, p_oct, 3'b000} + {2'b00, p_oct, 2'b00} + {4'd0, p_semi} - 8'd48;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl      <= C_IDLE;
      phase    <= PH_NAME;
      accum    <= '0;
      dflt_dur <= RST_DUR;
      dflt_oct <= {1'b0, RST_OCT};
      tempo    <= RST_TEMPO;
      whole_ms <= '0;
      p_semi   <= '0;
      p_oct    <= '0;
      p_dur    <= '0;
      p_valid  <= 1'b0;
      hdr_redo <= 1'b0;
    end else begin
      ctl      <= ctl_next;
      phase    <= phase_next;
      accum    <= accum_next;
      dflt_dur <= dflt_dur_next;
      dflt_oct <= dflt_oct_next;
      tempo    <= tempo_next;
      whole_ms <= whole_ms_next;
      p_semi   <= p_semi_next;
      p_oct    <= p_oct_next;
      p_dur    <= p_dur_next;
      p_valid  <= p_valid_next;
      hdr_redo <= hdr_redo_next;
    end
  end

  // Character latch.
  always_ff @(posedge clk) begin
    chr <= chr_next;
  end

  // Result register; a transfer on the output side frees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      is_rest     <= em_rest;
      note_index  <= em_idx;
      duration_ms <= em_dur;
      song_end    <= em_end;
    end
  end

  // Next state: one parser phase per cycle while stepping and not held by the output, divisions on the shared divider.
  always_comb begin
    ctl_next      = ctl;
    phase_next    = phase;
    chr_next      = chr;
    accum_next    = accum;
    dflt_dur_next = dflt_dur;
    dflt_oct_next = dflt_oct;
    tempo_next    = tempo;
    whole_ms_next = whole_ms;
    p_semi_next   = p_semi;
    p_oct_next    = p_oct;
    p_dur_next    = p_dur;
    p_valid_next  = p_valid;
    hdr_redo_next = hdr_redo;
    div_start     = 1'b0;
    div_dividend  = whole_ms;
    div_divisor   = (tempo == 16'd0) ? 16'd1 : tempo;
    emit          = 1'b0;
    em_rest       = (p_semi == 4'd0);
    em_idx        = (p_semi == 4'd0) ? 8'd0 : idx_raw;
    em_dur        = p_dur;
    em_end        = 1'b0;

    case (ctl)
      C_IDLE: begin
        if (in_valid) begin
          chr_next = char_code;
          ctl_next = C_STEP;
          if (song_start) begin
            phase_next    = PH_NAME;
            accum_next    = '0;
            dflt_dur_next = fb_dur;
            dflt_oct_next = {1'b0, fb_oct};
            tempo_next    = fb_tempo;
            whole_ms_next = '0;
            p_semi_next   = '0;
            p_oct_next    = '0;
            p_dur_next    = '0;
            p_valid_next  = 1'b0;
          end
        end
      end

      C_STEP: begin
        if (chr == CH_NUL) begin
          // End of string: flush the note in progress or a zero rest.
          if (phase == PH_DONE) begin
            ctl_next = C_IDLE;
          end else if (out_free) begin
            emit   = 1'b1;
            em_end = 1'b1;
            if (!(p_valid || phase == PH_NSHARP || phase == PH_NDOT ||
                  phase == PH_NOCT || phase == PH_NCOMMA)) begin
              em_rest = 1'b1;
              em_idx  = 8'd0;
              em_dur  = '0;
            end
            p_valid_next = 1'b0;
            accum_next   = '0;
            phase_next   = PH_DONE;
            ctl_next     = C_IDLE;
          end
        end else begin
          ctl_next = C_IDLE;
          case (phase)
            PH_NAME: if (chr == CH_COLON) phase_next = PH_HD;
            PH_HD: begin
              if (chr == CH_D) phase_next = PH_DEQ;
              else begin
                phase_next = PH_HO;
                ctl_next   = C_STEP;
              end
            end
            PH_DEQ: begin
              accum_next = '0;
              phase_next = PH_DNUM;
            end
            PH_DNUM: begin
              if (is_dig) begin
                accum_next = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];
              end else begin
                if (accum != 16'd0)
                  dflt_dur_next = (accum > 16'd255) ? 8'd255 : accum[7:0];
                accum_next = '0;
                phase_next = PH_HO;
              end
            end
            PH_HO: begin
              if (chr == CH_O) phase_next = PH_OEQ;
              else begin
                phase_next = PH_HB;
                ctl_next   = C_STEP;
              end
            end
            PH_OEQ: phase_next = PH_ODIG;
            PH_ODIG: begin
              if (chr >= 8'h33 && chr <= 8'h37) dflt_oct_next = dig;
              phase_next = PH_OCOMMA;
            end
            PH_OCOMMA: phase_next = PH_HB;
            PH_HB: begin
              if (chr == CH_B) phase_next = PH_BEQ;
              else begin
                div_start     = 1'b1;
                div_dividend  = MS_PER_MIN;
                hdr_redo_next = 1'b1;
                ctl_next      = C_HDR_DIV;
              end
            end
            PH_BEQ: begin
              accum_next = '0;
              phase_next = PH_BNUM;
            end
            PH_BNUM: begin
              if (is_dig) begin
                accum_next = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];
              end else begin
                tempo_next    = accum;
                div_start     = 1'b1;
                div_dividend  = MS_PER_MIN;
                div_divisor   = (accum == 16'd0) ? 16'd1 : accum;
                hdr_redo_next = 1'b0;
                ctl_next      = C_HDR_DIV;
              end
            end
            PH_NSTART: begin
              if (p_valid && !out_free) begin
                ctl_next = C_STEP;
              end else begin
                emit         = p_valid;
                p_valid_next = 1'b0;
                if (is_dig) begin
                  accum_next = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];
                end else begin
                  div_start    = 1'b1;
                  div_dividend = whole_ms;
                  div_divisor  = (accum != 16'd0) ? accum :
                                 (dflt_dur != 8'd0) ? {8'd0, dflt_dur} : 16'd1;
                  ctl_next     = C_NOTE_DIV;
                end
              end
            end
            PH_NSHARP: begin
              phase_next = PH_NDOT;
              if (chr == CH_SHARP) p_semi_next = p_semi + 4'd1;
              else ctl_next = C_STEP;
            end
            PH_NDOT: begin
              phase_next = PH_NOCT;
              if (chr == CH_DOT) p_dur_next = p_dur + {1'b0, p_dur[18:1]};
              else ctl_next = C_STEP;
            end
            PH_NOCT: begin
              phase_next = PH_NCOMMA;
              if (is_dig) p_oct_next = dig;
              else ctl_next = C_STEP;
            end
            PH_NCOMMA: begin
              p_valid_next = 1'b1;
              phase_next   = PH_NSTART;
              if (chr != CH_COMMA) ctl_next = C_STEP;
            end
            default: ;
          endcase
        end
      end

      C_HDR_DIV: begin
        if (div_done) begin
          whole_ms_next = {div_q[15:0], 2'b00};
          accum_next    = '0;
          phase_next    = PH_NSTART;
          ctl_next      = hdr_redo ? C_STEP : C_IDLE;
        end
      end

      C_NOTE_DIV: begin
        if (div_done) begin
          p_dur_next  = {1'b0, div_q};
          p_semi_next = letter_semitone(chr);
          p_oct_next  = dflt_oct;
          accum_next  = '0;
          phase_next  = PH_NSHARP;
          ctl_next    = C_IDLE;
        end
      end

      default: ctl_next = C_IDLE;
    endcase
  end

  // A division result arrives only while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (ctl == C_HDR_DIV || ctl == C_NOTE_DIV))
    else $error("divider result outside a wait state");
  // An event is never written over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free) else $error("result overwritten");
  // Once the song has ended no note is pending.
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |-> !p_valid) else $error("note pending after song end");

endmodule
